[rtl/biased_load_balanced_cell_picker_assert.svh]
// Assertion macros for the cell picker block.
`ifndef BIASED_LOAD_BALANCED_CELL_PICKER_ASSERT_SVH
`define BIASED_LOAD_BALANCED_CELL_PICKER_ASSERT_SVH
`ifndef SYNTHESIS
`define BLB_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define BLB_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define BLB_ASSERT_IMP(lbl, clk, rst, a, c)
`define BLB_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

[rtl/blb_pkg.sv]
// Shared types and constants of the cell picker.
`timescale 1ns / 1ps
package blb_pkg;
  localparam logic [1:0] KIND_REG  = 2'd0;
  localparam logic [1:0] KIND_SET  = 2'd1;
  localparam logic [1:0] KIND_PICK = 2'd2;
  localparam logic [1:0] KIND_NOP  = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  localparam logic [8:0] UNIT_WEIGHT = 9'd256;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] tag_id;
    logic [30:0] chunk_cnt;
    logic [63:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] picked_tag;
    logic [5:0]  entry_index;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SUM, S_AVG, S_CLASS, S_MOD, S_PDIV, S_SEL, S_OUT
  } state_t;

  // Start / done handshake with the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } div_rsp_t;
endpackage

[rtl/blb_if.sv]
// Valid/ready channel interfaces for input and result transactions.
`timescale 1ns / 1ps
interface blb_in_if;
  import blb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface blb_out_if;
  import blb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/blb_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, 64 bit.
`timescale 1ns / 1ps
module blb_div (
  input  logic              clk,
  input  logic              rst,
  input  blb_pkg::div_req_t req,
  output blb_pkg::div_rsp_t rsp
);
  import blb_pkg::*;

  logic [63:0] num;
  logic [63:0] den;
  logic [63:0] quo;
  logic [64:0] rem;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;

  // Shift next numerator bit into the partial remainder and try a subtract
  assign trial = {rem[63:0], num[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.num;
      den <= req.den;
      quo <= '0;
      rem <= '0;
    end else if (busy) begin
      num <= {num[62:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem[63:0];

  `include "biased_load_balanced_cell_picker_assert.svh"
  `BLB_ASSERT_NXT(a_div_len, clk, rst, req.start, busy)
  `BLB_ASSERT_IMP(a_div_done, clk, rst, done, !busy)
  `BLB_ASSERT_NXT(a_div_pulse, clk, rst, done, !done)
endmodule

[rtl/biased_load_balanced_cell_picker.sv]
// Top level of the biased load-balanced cell picker.
`timescale 1ns / 1ps
// Usage:
// in_ch (sink) takes one transaction per item: kind, tag_id, chunk_cnt,
// random_value. out_ch (source) gives exactly one result per item: status,
// picked_tag, entry_index. bias_scaled_we/bias_scaled write the bias register.
// Register, set and no-op items scan the table once.
// A pick also sums the chunk counts, divides the sum by the number n of
// registered cells on the shared 64-bit divider, classifies each entry,
// runs the modulo on the divider, divides the offset by the biased weight
// on the divider (or with a shift for the unit-weight group), then ranks
// each entry against all others by tag. A pick on an empty table goes
// from the scan straight to the result with status EMPTY.
// in_ch.ready is high only in the idle state; one item is in work at a time,
// and the next item is taken only once the result has been taken and the
// block is back in the idle state.
// The result sits in an output register until taken; while out_ch.ready is
// low the block waits and takes no new item.
// Reset empties the table and clears the bias to zero.
module biased_load_balanced_cell_picker #(
  parameter int MAX_CELLS = 16
) (
  input  logic         clk,
  input  logic         rst,
  blb_in_if.sink       in_ch,
  blb_out_if.source    out_ch,
  input  logic         bias_scaled_we,
  input  logic [15:0]  bias_scaled
);
  import blb_pkg::*;

  localparam int IW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CW = $clog2(MAX_CELLS + 1);

  logic [15:0] bias_q;
  logic [15:0] tags   [MAX_CELLS];
  logic [30:0] chunks [MAX_CELLS];
  logic        below  [MAX_CELLS];
  logic [CW-1:0] count;

  state_t state, state_next;
  in_item_t  item;
  out_item_t res;
  logic      res_valid;

  logic [CW-1:0] i, j;
  logic [CW-1:0] found_idx;
  logic          found;
  logic [63:0]   sum;
  logic [63:0]   avg;
  logic [CW-1:0] nlo, nhi;
  logic [CW-1:0] rank;
  logic [63:0]   tlo, wlo, rmod, kval;
  logic          in_lo;
  logic          div_started;
  logic [16:0]   wlo_s;
  logic [23:0]   tlo_mul;
  logic [63:0]   hi_off;
  logic [63:0]   hi_slot;

  div_req_t dreq;
  div_rsp_t drsp;

  blb_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) bias_q <= '0;
    else if (bias_scaled_we) bias_q <= bias_scaled;
  end

  // Weight of a below-average cell and the weight of that whole group
  assign wlo_s   = 17'd256 + {1'b0, bias_q};
  assign tlo_mul = {7'd0, wlo_s} * {{(24-CW){1'b0}}, nlo};

  // Unit-weight group: offset divided by 256 is a shift
  assign hi_off  = rmod - tlo;
  assign hi_slot = {8'd0, hi_off[63:8]};

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = res_valid;
  assign out_ch.data  = res;

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_ch.valid) begin
        state_next = S_SCAN;
      end
      S_SCAN: if (i >= count) begin
        state_next = (item.kind == KIND_PICK) ?
                     ((count == '0) ? S_OUT : S_SUM) : S_OUT;
      end
      S_SUM: if (i >= count) begin
        state_next = S_AVG;
      end
      S_AVG: if (drsp.done) begin
        state_next = S_CLASS;
      end
      S_CLASS: if (i >= count) begin
        state_next = S_MOD;
      end
      S_MOD: if (drsp.done) begin
        state_next = S_PDIV;
      end
      S_PDIV: if (!in_lo || drsp.done) begin
        state_next = S_SEL;
      end
      S_SEL: if (i >= count) begin
        state_next = S_OUT;
      end
      S_OUT: if (!res_valid) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Divider request outputs
  always_comb begin
    dreq = '0;
    case (state)
      S_AVG: begin
        dreq.start = !div_started;
        dreq.num   = sum;
        dreq.den   = {{(64-CW){1'b0}}, count};
      end
      S_MOD: begin
        dreq.start = !div_started;
        dreq.num   = item.random_value;
        dreq.den   = tlo + {{(64-CW-8){1'b0}}, nhi, 8'd0};
      end
      S_PDIV: begin
        dreq.start = !div_started && in_lo;
        dreq.num   = rmod;
        dreq.den   = wlo;
      end
      default: dreq = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      res_valid <= 1'b0;
      div_started <= 1'b0;
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      div_started <= (dreq.start || div_started) && !drsp.done
                     && (state_next == state);
      case (state)
        S_IDLE: if (in_ch.valid) begin
          item  <= in_ch.data;
          i     <= '0;
          found <= 1'b0;
          found_idx <= '0;
          res   <= '0;
        end
        S_SCAN: begin
          if (i < count) begin
            if (!found && tags[i[IW-1:0]] == item.tag_id) begin
              found <= 1'b1;
              found_idx <= i;
            end
            i <= i + 1'b1;
          end else begin
            i <= '0;
            sum <= '0;
            case (item.kind)
              KIND_REG: begin
                if (found) res.status <= ST_DUP;
                else if (count >= CW'(MAX_CELLS)) res.status <= ST_FULL;
                else begin
                  tags[count[IW-1:0]] <= item.tag_id;
                  chunks[count[IW-1:0]] <= '0;
                  res.entry_index <= 6'(count);
                  count <= count + 1'b1;
                end
              end
              KIND_SET: begin
                if (!found) res.status <= ST_UNKNOWN;
                else chunks[found_idx[IW-1:0]] <= item.chunk_cnt;
              end
              KIND_PICK: if (count == '0) res.status <= ST_EMPTY;
              default: res <= '0;
            endcase
          end
        end
        S_SUM: begin
          if (i < count) begin
            sum <= sum + {33'd0, chunks[i[IW-1:0]]};
            i <= i + 1'b1;
          end
        end
        S_AVG: if (drsp.done) begin
          avg <= drsp.quo;
          i <= '0;
          nlo <= '0;
          nhi <= '0;
        end
        S_CLASS: begin
          if (i < count) begin
            below[i[IW-1:0]] <= ({33'd0, chunks[i[IW-1:0]]} < avg);
            if ({33'd0, chunks[i[IW-1:0]]} < avg) nlo <= nlo + 1'b1;
            else nhi <= nhi + 1'b1;
            i <= i + 1'b1;
          end else begin
            wlo <= {47'd0, wlo_s};
            tlo <= {40'd0, tlo_mul};
          end
        end
        S_MOD: if (drsp.done) begin
          rmod  <= drsp.rem;
          in_lo <= drsp.rem < tlo;
        end
        S_PDIV: if (!in_lo || drsp.done) begin
          // Clamp the slot to the last member of its group
          if (in_lo) begin
            if (drsp.quo >= {{(64-CW){1'b0}}, nlo})
              kval <= {{(64-CW){1'b0}}, nlo} - 64'd1;
            else
              kval <= drsp.quo;
          end else begin
            if (hi_slot >= {{(64-CW){1'b0}}, nhi})
              kval <= {{(64-CW){1'b0}}, nhi} - 64'd1;
            else
              kval <= hi_slot;
          end
          i <= '0;
          j <= '0;
          rank <= '0;
        end
        S_SEL: begin
          // Rank of entry i inside its group, by ascending tag
          if (i < count) begin
            if (j < count) begin
              if (below[j[IW-1:0]] == below[i[IW-1:0]]
                  && tags[j[IW-1:0]] < tags[i[IW-1:0]])
                rank <= rank + 1'b1;
              j <= j + 1'b1;
            end else begin
              if (below[i[IW-1:0]] == in_lo
                  && {{(64-CW){1'b0}}, rank} == kval)
                res.picked_tag <= tags[i[IW-1:0]];
              rank <= '0;
              j <= '0;
              i <= i + 1'b1;
            end
          end
        end
        S_OUT: if (!res_valid && state_next == S_IDLE) begin
        end
        default: ;
      endcase
      if (state != S_OUT && state_next == S_OUT) res_valid <= 1'b1;
    end
  end

  `include "biased_load_balanced_cell_picker_assert.svh"
  `BLB_ASSERT_IMP(a_busy_not_ready, clk, rst, state != S_IDLE, !in_ch.ready)
  `BLB_ASSERT_IMP(a_count_max, clk, rst, 1'b1, count <= CW'(MAX_CELLS))
  `BLB_ASSERT_IMP(a_valid_in_out, clk, rst, res_valid, state == S_OUT)
endmodule
